// ===== src/broadcast_complex_vector_multiply_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the broadcast complex vector multiply block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_COMPLEX_VECTOR_MULTIPLY_ASSERT_SVH
`define BROADCAST_COMPLEX_VECTOR_MULTIPLY_ASSERT_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset
`define BCVM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bcvm: assertion failed");
// Same check, written as antecedent and consequent
`define BCVM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcvm: implication failed");
`else
`define BCVM_ASSERT(lbl, clk, rst_n, prop)
`define BCVM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/bcvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bcvm_pkg
// Shared types and constants of the broadcast complex vector multiply block.
// ----------------------------------------------------------------------------
package bcvm_pkg;

  // Sample format: signed Q1.(SampleWidth-1)
  localparam int unsigned SampleWidth        = 16;
  localparam int unsigned VectorDepthDefault = 256;
  localparam int unsigned IndexWidth         = 8;
  localparam int unsigned VecLenWidth        = 9;
  localparam int unsigned GroupWidth         = 16;
  localparam int unsigned CfgIndexWidth      = 2;
  localparam int unsigned CfgDataWidth       = 16;

  // Queue between front and back (power of two)
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QCountWidth = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgDirection     = 2'd0,
    CfgVectorLength  = 2'd1,
    CfgGroupLength   = 2'd2,
    CfgComplexEnable = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ModeLoad    = 1'b0,
    ModeElement = 1'b1
  } item_mode_e;

  typedef enum logic {
    DirRow = 1'b0,
    DirCol = 1'b1
  } direction_e;

  typedef struct packed {
    logic                          mode;
    logic signed [SampleWidth-1:0] data_re;
    logic signed [SampleWidth-1:0] data_im;
    logic [IndexWidth-1:0]         vector_index;
    logic                          last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] product_re;
    logic signed [SampleWidth-1:0] product_im;
    logic                          last_out;
  } out_item_t;

  typedef struct packed {
    direction_e             direction;
    logic [VecLenWidth-1:0] vector_length;
    logic [GroupWidth-1:0]  group_length;
    logic                   complex_enable;
  } cfg_t;

  // One matrix element paired with its vector entry
  typedef struct packed {
    logic signed [SampleWidth-1:0] elem_re;
    logic signed [SampleWidth-1:0] elem_im;
    logic signed [SampleWidth-1:0] vec_re;
    logic signed [SampleWidth-1:0] vec_im;
    logic                          last;
  } pair_t;

endpackage

// ===== src/bcvm_ram.sv =====
// ----------------------------------------------------------------------------
// bcvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcvm_ram #(
  parameter int unsigned Width     = 32,
  parameter int unsigned Depth     = 256,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrWidth-1:0] wr_addr_i,
  input  logic [Width-1:0]     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] rd_addr_i,
  output logic [Width-1:0]     rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/bcvm_front.sv =====
// ----------------------------------------------------------------------------
// bcvm_front
// Accepts items, writes vector loads to the store, and for matrix elements
// reads the current entry and steps the entry pointer and group counter.
// ----------------------------------------------------------------------------
module bcvm_front
  import bcvm_pkg::*;
#(
  parameter int unsigned VectorDepth = VectorDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  input  cfg_t                   cfg_i,
  input  logic [QCountWidth-1:0] queue_count_i,
  output logic                   push_o,
  output pair_t                  push_data_o
);

  // Only the first 256 entries are reachable through the index field
  localparam int unsigned IndexSpan  = 1 << IndexWidth;
  localparam int unsigned StoreDepth = (VectorDepth > IndexSpan) ? IndexSpan : VectorDepth;
  localparam int unsigned AddrWidth  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [VecLenWidth-1:0] EffMax = VecLenWidth'(StoreDepth);

  logic                   in_fire;
  logic                   is_elem;
  logic                   wr_en;
  logic                   rd_en;
  logic [2*SampleWidth-1:0] rd_data;
  logic [AddrWidth-1:0]   slot_lut [IndexSpan];
  logic [AddrWidth-1:0]   wr_slot;

  logic [AddrWidth-1:0]   ptr_q, ptr_d, ptr_adv;
  logic [GroupWidth-1:0]  grp_q, grp_d;
  logic [VecLenWidth-1:0] eff_len;
  logic [VecLenWidth-1:0] ptr_inc;
  logic [GroupWidth-1:0]  grp_len;
  logic [GroupWidth:0]    grp_inc;

  logic                          s1_valid_q;
  logic signed [SampleWidth-1:0] s1_re_q, s1_im_q;
  logic                          s1_last_q;
  logic [QCountWidth-1:0]        committed;

  // Load index modulo store depth, folded at elaboration
  for (genvar k = 0; k < IndexSpan; k++) begin : g_slot
    localparam int unsigned Slot = k % VectorDepth;
    assign slot_lut[k] = AddrWidth'(Slot);
  end

  // Credit check: room for everything in flight toward the queue
  assign committed  = queue_count_i + QCountWidth'(s1_valid_q);
  assign in_ready_o = committed < QCountWidth'(QueueDepth);

  assign in_fire = in_valid_i & in_ready_o;
  assign is_elem = in_data_i.mode == ModeElement;
  assign wr_en   = in_fire & ~is_elem;
  assign rd_en   = in_fire & is_elem;
  assign wr_slot = slot_lut[in_data_i.vector_index];

  // Vector store, real and imaginary parts side by side
  bcvm_ram #(
    .Width (2 * SampleWidth),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_slot),
    .wr_data_i ({in_data_i.data_re, in_data_i.data_im}),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data)
  );

  // Effective lengths
  always_comb begin
    if (cfg_i.vector_length == '0) begin
      eff_len = VecLenWidth'(1);
    end else if (cfg_i.vector_length > EffMax) begin
      eff_len = EffMax;
    end else begin
      eff_len = cfg_i.vector_length;
    end
    grp_len = (cfg_i.group_length == '0) ? GroupWidth'(1) : cfg_i.group_length;
  end

  assign ptr_inc = VecLenWidth'(ptr_q) + VecLenWidth'(1);
  assign ptr_adv = (ptr_inc >= eff_len) ? '0 : AddrWidth'(ptr_inc);
  assign grp_inc = {1'b0, grp_q} + (GroupWidth + 1)'(1);

  // Position sequencing after each matrix element
  always_comb begin
    ptr_d = ptr_q;
    grp_d = grp_q;
    if (rd_en) begin
      if (in_data_i.last_element) begin
        ptr_d = '0;
        grp_d = '0;
      end else if (cfg_i.direction == DirCol) begin
        ptr_d = ptr_adv;
        grp_d = '0;
      end else if (grp_inc >= {1'b0, grp_len}) begin
        ptr_d = ptr_adv;
        grp_d = '0;
      end else begin
        grp_d = grp_inc[GroupWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      grp_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      ptr_q      <= ptr_d;
      grp_q      <= grp_d;
      s1_valid_q <= rd_en;
    end
  end

  // Element held while the store read completes
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_re_q   <= in_data_i.data_re;
      s1_im_q   <= in_data_i.data_im;
      s1_last_q <= in_data_i.last_element;
    end
  end

  assign push_o              = s1_valid_q;
  assign push_data_o.elem_re = s1_re_q;
  assign push_data_o.elem_im = s1_im_q;
  assign push_data_o.vec_re  = rd_data[2*SampleWidth-1:SampleWidth];
  assign push_data_o.vec_im  = rd_data[SampleWidth-1:0];
  assign push_data_o.last    = s1_last_q;

endmodule

// ===== src/bcvm_queue.sv =====
// ----------------------------------------------------------------------------
// bcvm_queue
// Short FIFO of element and entry pairs between the front and the back.
// ----------------------------------------------------------------------------
`include "broadcast_complex_vector_multiply_assert.svh"

module bcvm_queue
  import bcvm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pair_t                  push_data_i,
  input  logic                   pop_i,
  output logic                   head_valid_o,
  output pair_t                  head_o,
  output logic [QCountWidth-1:0] count_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  pair_t                  entry_q [QueueDepth];
  logic [PtrWidth-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCountWidth-1:0] count_q;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCountWidth'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCountWidth'(1);
      end
    end
  end

  assign head_valid_o = count_q != '0;
  assign head_o       = entry_q[rd_ptr_q];
  assign count_o      = count_q;

  // Front credit must keep the queue from overflowing
  `BCVM_ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, push_i, count_q < QCountWidth'(QueueDepth))
  `BCVM_ASSERT_IMPLY(a_no_underflow, clk_i, rst_ni, pop_i, count_q != '0)
  `BCVM_ASSERT(a_count_step, clk_i, rst_ni, (push_i && !pop_i) |=> (count_q == $past(count_q) + QCountWidth'(1)))

endmodule

// ===== src/bcvm_back.sv =====
// ----------------------------------------------------------------------------
// bcvm_back
// Two-stage multiply: products, then sum with rounding and saturation into
// the output register.
// ----------------------------------------------------------------------------
module bcvm_back
  import bcvm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      head_valid_i,
  input  pair_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned ProdWidth = 2 * SampleWidth;
  localparam int unsigned SumWidth  = ProdWidth + 1;

  // Round half up, shift down to sample scale, saturate
  function automatic logic signed [SampleWidth-1:0] round_sat(
    input logic signed [SumWidth-1:0] sum
  );
    logic signed [SumWidth-1:0]      biased;
    logic signed [SampleWidth+1:0]   shifted;
    logic signed [SampleWidth-1:0]   res;
    biased  = sum + SumWidth'(1 << (SampleWidth - 2));
    shifted = (SampleWidth + 2)'(biased >>> (SampleWidth - 1));
    if (shifted[SampleWidth+1:SampleWidth-1] == '0 ||
        shifted[SampleWidth+1:SampleWidth-1] == '1) begin
      res = shifted[SampleWidth-1:0];
    end else if (shifted[SampleWidth+1]) begin
      res = {1'b1, {(SampleWidth-1){1'b0}}};
    end else begin
      res = {1'b0, {(SampleWidth-1){1'b1}}};
    end
    return res;
  endfunction

  logic                        p1_valid_q;
  logic signed [ProdWidth-1:0] rr_q, ii_q, ri_q, ir_q;
  logic                        p1_last_q;
  logic                        p1_ready, p2_ready;

  logic                        out_valid_q;
  out_item_t                   out_q;

  logic signed [SumWidth-1:0]  sum_re, sum_im;

  // Stall chain from the output back to the queue
  assign p2_ready = ~out_valid_q | out_ready_i;
  assign p1_ready = ~p1_valid_q | p2_ready;
  assign pop_o    = head_valid_i & p1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p1_ready) begin
        p1_valid_q <= head_valid_i;
      end
      if (p2_ready) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  // Stage 1: four independent products
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rr_q      <= head_i.elem_re * head_i.vec_re;
      ii_q      <= head_i.elem_im * head_i.vec_im;
      ri_q      <= head_i.elem_re * head_i.vec_im;
      ir_q      <= head_i.elem_im * head_i.vec_re;
      p1_last_q <= head_i.last;
    end
  end

  // Stage 2: combine products
  always_comb begin
    if (cfg_i.complex_enable) begin
      sum_re = SumWidth'(rr_q) - SumWidth'(ii_q);
    end else begin
      sum_re = SumWidth'(rr_q);
    end
    sum_im = SumWidth'(ri_q) + SumWidth'(ir_q);
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q && p2_ready) begin
      out_q.product_re <= round_sat(sum_re);
      out_q.product_im <= cfg_i.complex_enable ? round_sat(sum_im) : '0;
      out_q.last_out   <= p1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/broadcast_complex_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// broadcast_complex_vector_multiply
// Multiplies a streamed matrix by a stored, broadcast complex vector.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, always ready) writes registers
//   by index: direction, vector length, group length, complex enable.
//   Write them only while the block is idle.
//   Input channel (in_valid_i/in_ready_o): a mode-0 item loads one vector
//   entry and gives no result; a mode-1 item is a matrix element and gives
//   exactly one product on the output channel (out_valid_o/out_ready_i).
//   Throughput is one item per cycle while the receiver does not stall. An
//   accepted element passes the vector store read, the queue, the products,
//   then sum, rounding and saturation into the output register.
//   A 4-entry queue sits between the store read and the multiplier; while the
//   receiver stalls, input items keep being taken until both multiply stages
//   are full and the queue plus any store read in flight holds 4, then in_ready_o drops.
//   Reset restores the register defaults and clears the entry pointer and
//   group counter; the vector store is not cleared and must be loaded
//   before use.
// ----------------------------------------------------------------------------
module broadcast_complex_vector_multiply
  import bcvm_pkg::*;
#(
  parameter int unsigned VectorDepth = VectorDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_data_o
);

  cfg_t                   cfg_q;
  logic [QCountWidth-1:0] queue_count;
  logic                   push;
  pair_t                  push_data;
  logic                   pop;
  logic                   head_valid;
  pair_t                  head;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction      <= DirCol;
      cfg_q.vector_length  <= VecLenWidth'(256);
      cfg_q.group_length   <= GroupWidth'(1);
      cfg_q.complex_enable <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgDirection:     cfg_q.direction      <= direction_e'(cfg_data_i[0]);
        CfgVectorLength:  cfg_q.vector_length  <= cfg_data_i[VecLenWidth-1:0];
        CfgGroupLength:   cfg_q.group_length   <= cfg_data_i[GroupWidth-1:0];
        CfgComplexEnable: cfg_q.complex_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bcvm_front #(
    .VectorDepth (VectorDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .cfg_i         (cfg_q),
    .queue_count_i (queue_count),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  bcvm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (queue_count)
  );

  bcvm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
